FILE: sv/ple_pkg.sv
`default_nettype none

package ple_pkg;

	// default list depth
	localparam int DefCapacity = 64;

	// field widths
	localparam int OpW     = 2;
	localparam int PosW    = 7;
	localparam int ValW    = 32;
	localparam int CntOutW = 7;

	// stream widths, padded to whole bytes
	localparam int InDataW  = 48;
	localparam int OutDataW = 48;
	localparam int OutPadW  = OutDataW - (ValW + 1 + 2 + CntOutW);

	typedef enum logic [1:0] {
		OP_INSERT = 2'd0,
		OP_DELETE = 2'd1,
		OP_READ   = 2'd2,
		OP_SEARCH = 2'd3
	} op_t;

	typedef enum logic [1:0] {
		ST_DONE  = 2'd0,
		ST_RANGE = 2'd1,
		ST_FULL  = 2'd2
	} status_t;

	// one request
	typedef struct packed {
		logic signed [ValW-1:0] value;
		logic [PosW-1:0]        position;
		op_t                    op;
	} req_t;

	// one response, count travels separately
	typedef struct packed {
		logic signed [ValW-1:0] read_value;
		logic                   found;
		status_t                status;
	} res_t;

endpackage

`default_nettype wire

FILE: sv/positional_list_engine.sv
// Sequencing: insert and delete move each entry that lies past the position, a search
//   stops at the first hit or after the last entry, and rejected requests and a search
//   of an empty list go straight to the result.
// Throughput: one request at a time, a new one taken only after the last result is
//   handed on, with moves and scans stepping the entry memory one entry per cycle.
// Reset: arst_n clears the count and the sequencer; entry memory is not cleared.
`default_nettype none

module positional_list_engine
	import ple_pkg::*;
#(
	parameter int CAPACITY = DefCapacity
) (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                s_axis_tvalid,
	output logic                     s_axis_tready,
	// op[1:0], position[8:2], value[40:9], zero pad above
	input  wire logic [InDataW-1:0]  s_axis_tdata,
	output logic                     m_axis_tvalid,
	input  wire logic                m_axis_tready,
	// read_value[31:0], found[32], status[34:33], count[41:35], zero pad above
	output logic [OutDataW-1:0]      m_axis_tdata
);

	localparam int AW = $clog2(CAPACITY);
	localparam int CW = $clog2(CAPACITY + 1);

	req_t            req;
	res_t            res;
	logic            res_valid, res_ready;
	logic [CW-1:0]   cnt;
	logic            ram_we, ram_re;
	logic [AW-1:0]   ram_waddr, ram_raddr;
	logic [ValW-1:0] ram_wdata, ram_rdata;

	logic                out_valid_q;
	logic [OutDataW-1:0] out_data_q;

	// unpack the input transfer
	assign req.op       = op_t'(s_axis_tdata[OpW-1:0]);
	assign req.position = s_axis_tdata[OpW +: PosW];
	assign req.value    = s_axis_tdata[OpW + PosW +: ValW];

	ple_ctrl #(
		.CAPACITY (CAPACITY)
	) u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (s_axis_tvalid),
		.req_ready (s_axis_tready),
		.req       (req),
		.res_valid (res_valid),
		.res_ready (res_ready),
		.res       (res),
		.cnt       (cnt),
		.ram_we    (ram_we),
		.ram_waddr (ram_waddr),
		.ram_wdata (ram_wdata),
		.ram_re    (ram_re),
		.ram_raddr (ram_raddr),
		.ram_rdata (ram_rdata)
	);

	ple_ram #(
		.WIDTH (ValW),
		.DEPTH (CAPACITY)
	) u_entries (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.re    (ram_re),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	// output register
	assign res_ready = !out_valid_q || m_axis_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (res_valid && res_ready) begin
			out_valid_q <= 1'b1;
		end else if (m_axis_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (res_valid && res_ready) begin
			out_data_q <= {{OutPadW{1'b0}}, CntOutW'(cnt), res.status, res.found,
				res.read_value};
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = out_data_q;

endmodule

`default_nettype wire

FILE: sv/ple_ram.sv
`default_nettype none

module ple_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 64,
	localparam int AW = $clog2(DEPTH)
) (
	input  wire logic             clk,
	input  wire logic             we,
	input  wire logic [AW-1:0]    waddr,
	input  wire logic [WIDTH-1:0] wdata,
	input  wire logic             re,
	input  wire logic [AW-1:0]    raddr,
	output logic      [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	// one write port, one registered read port
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

`default_nettype wire

FILE: sv/ple_ctrl.sv
`default_nettype none

module ple_ctrl
	import ple_pkg::*;
#(
	parameter int CAPACITY = DefCapacity,
	localparam int AW = $clog2(CAPACITY),
	localparam int CW = $clog2(CAPACITY + 1)
) (
	input  wire logic            clk,
	input  wire logic            arst_n,
	// request side
	input  wire logic            req_valid,
	output logic                 req_ready,
	input  wire req_t            req,
	// response side
	output logic                 res_valid,
	input  wire logic            res_ready,
	output res_t                 res,
	output logic [CW-1:0]        cnt,
	// entry memory
	output logic                 ram_we,
	output logic [AW-1:0]        ram_waddr,
	output logic [ValW-1:0]      ram_wdata,
	output logic                 ram_re,
	output logic [AW-1:0]        ram_raddr,
	input  wire logic [ValW-1:0] ram_rdata
);

	localparam int CMPW = (CW > PosW) ? CW : PosW;

	typedef enum logic [6:0] {
		S_IDLE = 7'b0000001,
		S_MOVE = 7'b0000010,
		S_FIN  = 7'b0000100,
		S_RDA  = 7'b0001000,
		S_RDD  = 7'b0010000,
		S_SCAN = 7'b0100000,
		S_DONE = 7'b1000000
	} state_t;

	state_t          state_q, state_d;
	logic [CW-1:0]   cnt_q, cnt_d;
	logic            rd_on_q, rd_on_d;
	logic            mv_q, mv_d;
	logic [AW-1:0]   src_q, src_d;
	logic [AW-1:0]   last_q, last_d;
	logic [AW-1:0]   dst_q, dst_d;
	logic [AW-1:0]   pos_q, pos_d;
	op_t             op_q, op_d;
	logic [ValW-1:0] val_q, val_d;
	res_t            res_q, res_d;

	logic [CMPW-1:0] pos_x, pos_p1_x, cnt_x;
	logic [AW-1:0]   pos_a, cnt_m1_a;
	logic            full, down;
	logic [AW-1:0]   src_up, src_dn;

	assign pos_x    = CMPW'(req.position);
	assign pos_p1_x = pos_x + CMPW'(1);
	assign cnt_x    = CMPW'(cnt_q);
	assign pos_a    = AW'(req.position);
	assign cnt_m1_a = AW'(cnt_q - CW'(1));
	assign full     = (cnt_q == CW'(CAPACITY));

	// shared address stepper: insert walks down, delete and search walk up
	assign down   = (op_q == OP_INSERT);
	assign src_up = src_q + AW'(1);
	assign src_dn = src_q - AW'(1);

	// sequencer
	always_comb begin
		state_d   = state_q;
		cnt_d     = cnt_q;
		rd_on_d   = rd_on_q;
		mv_d      = 1'b0;
		src_d     = src_q;
		last_d    = last_q;
		dst_d     = dst_q;
		pos_d     = pos_q;
		op_d      = op_q;
		val_d     = val_q;
		res_d     = res_q;
		ram_we    = 1'b0;
		ram_waddr = dst_q;
		ram_wdata = ram_rdata;
		ram_re    = 1'b0;
		ram_raddr = src_q;
		case (state_q)
			S_IDLE: begin
				if (req_valid) begin
					op_d             = req.op;
					pos_d            = pos_a;
					val_d            = req.value;
					res_d.read_value = '0;
					res_d.found      = 1'b0;
					res_d.status     = ST_DONE;
					state_d          = S_DONE;
					case (req.op)
						OP_INSERT: begin
							if (pos_x > cnt_x) begin
								res_d.status = ST_RANGE;
							end else if (full) begin
								res_d.status = ST_FULL;
							end else if (pos_x == cnt_x) begin
								state_d = S_FIN;
							end else begin
								src_d   = cnt_m1_a;
								last_d  = pos_a;
								rd_on_d = 1'b1;
								state_d = S_MOVE;
							end
						end
						OP_DELETE: begin
							if (pos_x >= cnt_x) begin
								res_d.status = ST_RANGE;
							end else if (pos_p1_x == cnt_x) begin
								state_d = S_FIN;
							end else begin
								src_d   = AW'(pos_p1_x);
								last_d  = cnt_m1_a;
								rd_on_d = 1'b1;
								state_d = S_MOVE;
							end
						end
						OP_READ: begin
							if (pos_x >= cnt_x) begin
								res_d.status = ST_RANGE;
							end else begin
								src_d   = pos_a;
								state_d = S_RDA;
							end
						end
						default: begin
							if (cnt_q != '0) begin
								src_d   = '0;
								last_d  = cnt_m1_a;
								rd_on_d = 1'b1;
								state_d = S_SCAN;
							end
						end
					endcase
				end
			end
			// read one entry, write it one slot over in the next cycle
			S_MOVE: begin
				ram_re = rd_on_q;
				mv_d   = rd_on_q;
				ram_we = mv_q;
				if (rd_on_q) begin
					dst_d = down ? src_up : src_dn;
					if (src_q == last_q) begin
						rd_on_d = 1'b0;
					end else begin
						src_d = down ? src_dn : src_up;
					end
				end else begin
					state_d = S_FIN;
				end
			end
			S_FIN: begin
				if (op_q == OP_INSERT) begin
					ram_we    = 1'b1;
					ram_waddr = pos_q;
					ram_wdata = val_q;
					cnt_d     = cnt_q + CW'(1);
				end else begin
					cnt_d = cnt_q - CW'(1);
				end
				state_d = S_DONE;
			end
			S_RDA: begin
				ram_re  = 1'b1;
				state_d = S_RDD;
			end
			S_RDD: begin
				res_d.read_value = ram_rdata;
				state_d          = S_DONE;
			end
			// compare each entry as it comes out, stop on the first hit
			S_SCAN: begin
				ram_re = rd_on_q;
				mv_d   = rd_on_q;
				if (rd_on_q) begin
					if (src_q == last_q) begin
						rd_on_d = 1'b0;
					end else begin
						src_d = src_up;
					end
				end
				if (mv_q && (ram_rdata == val_q)) begin
					res_d.found = 1'b1;
					rd_on_d     = 1'b0;
					state_d     = S_DONE;
				end else if (mv_q && !rd_on_q) begin
					state_d = S_DONE;
				end
			end
			S_DONE: begin
				if (res_ready) begin
					state_d = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			cnt_q   <= '0;
			rd_on_q <= 1'b0;
			mv_q    <= 1'b0;
		end else begin
			state_q <= state_d;
			cnt_q   <= cnt_d;
			rd_on_q <= rd_on_d;
			mv_q    <= mv_d;
		end
	end

	// payload
	always_ff @(posedge clk) begin
		src_q  <= src_d;
		last_q <= last_d;
		dst_q  <= dst_d;
		pos_q  <= pos_d;
		op_q   <= op_d;
		val_q  <= val_d;
		res_q  <= res_d;
	end

	assign req_ready = (state_q == S_IDLE);
	assign res_valid = (state_q == S_DONE);
	assign res       = res_q;
	assign cnt       = cnt_q;

endmodule

`default_nettype wire

FILE: sv/ple_checker.sv
`default_nettype none

module ple_checker
	import ple_pkg::*;
#(
	parameter int CAPACITY = DefCapacity
) (
	input wire logic                clk,
	input wire logic                arst_n,
	input wire logic                s_axis_tvalid,
	input wire logic                s_axis_tready,
	input wire logic                m_axis_tvalid,
	input wire logic                m_axis_tready,
	input wire logic [OutDataW-1:0] m_axis_tdata
);

	// not ready in the cycle after taking a request
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
		else $error("ready right after input transfer");

	// stalled result holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
		else $error("stalled result changed");

	// full status only with a full list
	a_full_count: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && (m_axis_tdata[34:33] == ST_FULL)
		|-> m_axis_tdata[41:35] == CntOutW'(CAPACITY))
		else $error("full status with list not full");

	// a hit is a clean search result
	a_found_clean: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tdata[32]
		|-> (m_axis_tdata[34:33] == ST_DONE) && (m_axis_tdata[31:0] == '0))
		else $error("found set on a non-search result");

	// count stays within capacity
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> (CAPACITY > 127) || (int'(m_axis_tdata[41:35]) <= CAPACITY))
		else $error("count above capacity");

endmodule

bind positional_list_engine ple_checker #(
	.CAPACITY (CAPACITY)
) u_ple_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.s_axis_tvalid (s_axis_tvalid),
	.s_axis_tready (s_axis_tready),
	.m_axis_tvalid (m_axis_tvalid),
	.m_axis_tready (m_axis_tready),
	.m_axis_tdata  (m_axis_tdata)
);

`default_nettype wire

FILE: dv/tb_positional_list_engine.sv
`timescale 1ns / 100ps

module tb_positional_list_engine;
	import ple_pkg::*;

	localparam int ListDepth  = DefCapacity;
	localparam int StallLimit = 4000;
	localparam int DrainWait  = ListDepth + 16;
	localparam int HoldCycles = 300;

	// expected response of one request
	typedef struct {
		logic signed [ValW-1:0] read_value;
		logic                   found;
		status_t                status;
		logic [CntOutW-1:0]     count;
	} reply_t;

	// shadow copy of the list; predicts each response and checks it on arrival
	class list_shadow;
		logic signed [ValW-1:0] slots [ListDepth];
		int                     fill;
		reply_t                 pending_replies[$];
		int                     mismatches;

		function new();
			fill = 0;
			mismatches = 0;
		endfunction

		function int pending();
			return pending_replies.size();
		endfunction

		// update the shadow list for an accepted request and queue its response
		function void apply_request(op_t op, logic [PosW-1:0] pos, logic signed [ValW-1:0] val);
			reply_t r;
			r.read_value = '0;
			r.found      = 1'b0;
			r.status     = ST_DONE;
			case (op)
				OP_INSERT: begin
					if (pos > fill) r.status = ST_RANGE;
					else if (fill >= ListDepth) r.status = ST_FULL;
					else begin
						for (int i = fill; i > pos; i--) slots[i] = slots[i-1];
						slots[pos] = val;
						fill++;
					end
				end
				OP_DELETE: begin
					if (pos >= fill) r.status = ST_RANGE;
					else begin
						for (int i = pos; i + 1 < fill; i++) slots[i] = slots[i+1];
						fill--;
					end
				end
				OP_READ: begin
					if (pos >= fill) r.status = ST_RANGE;
					else r.read_value = slots[pos];
				end
				default: begin
					for (int i = 0; i < fill; i++) begin
						if (slots[i] == val) r.found = 1'b1;
					end
				end
			endcase
			r.count = fill[CntOutW-1:0];
			pending_replies.push_back(r);
		endfunction

		function void compare(string field, logic [31:0] want, logic [31:0] got);
			if (want !== got) begin
				$error("%s: expected %0d, got %0d", field, want, got);
				mismatches++;
			end
		endfunction

		// match one output transfer against the oldest queued response
		function void check_response(logic [OutDataW-1:0] beat);
			reply_t want;
			if (pending_replies.size() == 0) begin
				$error("response with no request outstanding: %h", beat);
				mismatches++;
				return;
			end
			want = pending_replies.pop_front();
			compare("read_value", want.read_value, beat[31:0]);
			compare("found", want.found, beat[32]);
			compare("status", want.status, beat[34:33]);
			compare("count", want.count, beat[41:35]);
		endfunction
	endclass

	logic                clk = 1'b0;
	logic                arst_n = 1'b0;
	logic                s_axis_tvalid = 1'b0;
	logic                s_axis_tready;
	logic [InDataW-1:0]  s_axis_tdata = '0;
	logic                m_axis_tvalid;
	logic                m_axis_tready = 1'b0;
	logic [OutDataW-1:0] m_axis_tdata;

	list_shadow sb;
	bit         steady = 1'b0;     // no idling on either side
	bit         hold_sink = 1'b0;  // request a long receiver hold-off
	int         stalled_cycles = 0;

	positional_list_engine #(.CAPACITY(ListDepth)) u_top (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata)
	);

	always #5 clk = ~clk;

	// receiver: random back-pressure, plus one long hold-off on request
	initial begin
		forever begin
			@(posedge clk);
			if (hold_sink) begin
				hold_sink = 1'b0;
				m_axis_tready <= 1'b0;
				repeat (HoldCycles) @(posedge clk);
			end
			m_axis_tready <= steady || ($urandom_range(99) >= 29);
		end
	end

	// outputs are stable mid-cycle; a transfer seen here lands at the next rising edge
	always @(negedge clk) begin
		if (arst_n) begin
			if (m_axis_tvalid && m_axis_tready) sb.check_response(m_axis_tdata);
			if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
				stalled_cycles = 0;
			end else begin
				stalled_cycles++;
				if (stalled_cycles >= StallLimit) begin
					$display("Mismatches found");
					$finish;
				end
			end
		end
	end

	// offer one request and hold it until the transfer
	task automatic send_request(op_t op, logic [PosW-1:0] pos, logic signed [ValW-1:0] val);
		logic took;
		while (!steady && $urandom_range(99) < 29) begin
			s_axis_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_axis_tdata  <= {{(InDataW - ValW - PosW - OpW){1'b0}}, val, pos, op};
		s_axis_tvalid <= 1'b1;
		do begin
			@(negedge clk);
			took = s_axis_tready;
			@(posedge clk);
		end while (!took);
		sb.apply_request(op, pos, val);
	endtask

	// small pool for duplicates, extremes, values already stored, full range
	function automatic logic signed [ValW-1:0] pick_value();
		int roll;
		roll = $urandom_range(99);
		if (roll < 30) return 32'($urandom_range(6)) - 32'd3;
		if (roll < 40) begin
			case ($urandom_range(3))
				0: return 32'h8000_0000;
				1: return 32'h7fff_ffff;
				2: return '0;
				default: return '1;
			endcase
		end
		if (roll < 60 && sb.fill > 0) return sb.slots[$urandom_range(sb.fill - 1)];
		return $urandom;
	endfunction

	// mostly in-range positions for the current list, some out-of-range noise
	task automatic random_phase(int n, int ins_w, int del_w, int rd_w);
		op_t             op;
		logic [PosW-1:0] pos;
		int              roll;
		repeat (n) begin
			roll = $urandom_range(99);
			if (roll < ins_w) op = OP_INSERT;
			else if (roll < ins_w + del_w) op = OP_DELETE;
			else if (roll < ins_w + del_w + rd_w) op = OP_READ;
			else op = OP_SEARCH;
			if ($urandom_range(99) < 85) begin
				case (op)
					OP_INSERT: pos = PosW'($urandom_range(sb.fill));
					OP_SEARCH: pos = PosW'($urandom_range(ListDepth));
					default:   pos = (sb.fill == 0) ? '0 : PosW'($urandom_range(sb.fill - 1));
				endcase
			end else begin
				pos = PosW'($urandom_range(ListDepth));
			end
			send_request(op, pos, pick_value());
		end
	endtask

	initial begin
		sb = new();
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;

		// empty list: every position is out of range, search misses
		send_request(OP_SEARCH, 7'd0, 32'sd5);
		send_request(OP_READ, 7'd0, '0);
		send_request(OP_DELETE, 7'd0, '0);
		send_request(OP_DELETE, 7'd64, '0);
		send_request(OP_INSERT, 7'd1, 32'sd9);
		send_request(OP_INSERT, 7'd64, 32'sd9);
		// build a short list at front, end and middle
		send_request(OP_INSERT, 7'd0, 32'h7fff_ffff);
		send_request(OP_INSERT, 7'd0, 32'h8000_0000);
		send_request(OP_INSERT, 7'd2, '1);
		send_request(OP_INSERT, 7'd1, '0);
		send_request(OP_READ, 7'd0, '0);
		send_request(OP_READ, 7'd1, '0);
		send_request(OP_READ, 7'd2, '0);
		send_request(OP_READ, 7'd3, '0);
		send_request(OP_READ, 7'd4, '0);
		send_request(OP_SEARCH, 7'd0, 32'h8000_0000);
		send_request(OP_SEARCH, 7'd127, '1);
		send_request(OP_SEARCH, 7'd0, 32'sd1);
		// remove middle, last, first
		send_request(OP_DELETE, 7'd1, '0);
		send_request(OP_DELETE, 7'd2, '0);
		send_request(OP_DELETE, 7'd0, '0);
		send_request(OP_READ, 7'd0, '0);
		send_request(OP_READ, 7'd1, '0);
		send_request(OP_SEARCH, 7'd0, $urandom);

		random_phase(150, 35, 25, 20);

		// fill to capacity and keep pushing, no idling
		steady = 1'b1;
		random_phase(200, 70, 5, 15);
		steady = 1'b0;

		// drain with a long receiver hold-off at the start
		hold_sink = 1'b1;
		random_phase(200, 10, 60, 15);

		// sender pause until the block is quiet
		s_axis_tvalid <= 1'b0;
		while (sb.pending() != 0) @(posedge clk);
		random_phase(280, 35, 25, 20);

		@(posedge clk);
		s_axis_tvalid <= 1'b0;
		while (sb.pending() != 0) @(posedge clk);
		repeat (DrainWait) @(posedge clk);
		if (sb.mismatches == 0) begin
			$display("No mismatches found");
		end else begin
			$display("Mismatches found");
		end
		$finish;
	end

endmodule

FILE: positional_list_engine.f
sv/ple_pkg.sv
sv/ple_ram.sv
sv/ple_ctrl.sv
sv/positional_list_engine.sv
sv/ple_checker.sv
dv/tb_positional_list_engine.sv
